// File: hw/rtl/imeh_pkg.sv
// Shared types and constants of the indexed max event heap.
package imeh_pkg;

   // Handle space: handles are never reused
   localparam int HANDLES = 1024;
   localparam int HW      = 10;

   typedef enum logic [1:0] {
      ACT_INSERT,
      ACT_POP,
      ACT_REMOVE,
      ACT_UNUSED
   } action_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_EMPTY,
      ST_FULL,
      ST_EXHAUSTED,
      ST_DEAD
   } rsp_status_type;

   // One heap entry: key, payload and the handle it was given
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [15:0]        leaf_ref;
      logic               event_kind;
      logic [HW-1:0]      handle;
   } node_type;

   typedef struct packed {
      rsp_status_type     status;
      logic [HW-1:0]      assigned_id;
      logic signed [31:0] top_key;
      logic signed [31:0] top_center_x;
      logic signed [31:0] top_center_y;
      logic [15:0]        top_leaf_ref;
      logic               top_event_kind;
   } rsp_word_type;

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [4:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_SET_STATUS,
      OP_INS_START,
      OP_POP_START,
      OP_POP_TOP,
      OP_TAKE_LAST,
      OP_RD_HANDLE,
      OP_REM_START,
      OP_REM_OLD,
      OP_RD_PARENT,
      OP_MOVE_PARENT,
      OP_RD_LEFT,
      OP_LATCH_LEFT,
      OP_MOVE_CHILD,
      OP_PLACE,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type      op;
      rsp_status_type code;
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       exhausted;
      logic       empty;
      logic       live_ok;
      logic       is_last;
      logic       grows;
      logic       at_root;
      logic       up_swap;
      logic       has_left;
      logic       down_stay;
   } dp_stat_type;

endpackage

// File: hw/rtl/imeh_if.sv
// Request and response channel interfaces of the event heap.
interface imeh_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] key;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic [15:0]        leaf_ref;
   logic               event_kind;
   logic [9:0]         target_id;

   modport source (output valid, action, key, center_x, center_y, leaf_ref, event_kind,
                   target_id, input ready);
   modport sink   (input valid, action, key, center_x, center_y, leaf_ref, event_kind,
                   target_id, output ready);
endinterface

interface imeh_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [9:0]         assigned_id;
   logic signed [31:0] top_key;
   logic signed [31:0] top_center_x;
   logic signed [31:0] top_center_y;
   logic [15:0]        top_leaf_ref;
   logic               top_event_kind;

   modport source (output valid, status, assigned_id, top_key, top_center_x, top_center_y,
                   top_leaf_ref, top_event_kind, input ready);
   modport sink   (input valid, status, assigned_id, top_key, top_center_x, top_center_y,
                   top_leaf_ref, top_event_kind, output ready);
endinterface

// File: hw/rtl/imeh_ram.sv
// Generic simple dual-port RAM with registered read.
module imeh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/imeh_dp.sv
// Heap datapath: storage, moving entry, index math and result registers.
module imeh_dp import imeh_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   input  logic [1:0]   req_action,
   input  node_type     req_node,
   input  logic [HW-1:0] req_target,
   output rsp_word_type out_word
);

   localparam int SW  = $clog2(CAPACITY);
   localparam int CW  = SW + 1;
   localparam int XW  = SW + 2;
   localparam int HSW = SW + 1;
   localparam int NW  = $bits(node_type);

   action_type     action_ff,  action_in;
   node_type       req_ff,     req_in;
   logic [HW-1:0]  target_ff,  target_in;
   logic [CW-1:0]  fill_ff,    fill_in;
   logic [HW:0]    next_ff,    next_in;
   logic [SW-1:0]  cur_ff,     cur_in;
   node_type       elem_ff,    elem_in;
   node_type       left_ff,    left_in;
   logic [31:0]    old_key_ff, old_key_in;
   rsp_word_type   res_ff,     res_in;
   rsp_word_type   out_ff,     out_in;

   logic           h_wr_en;
   logic [SW-1:0]  h_wr_addr;
   node_type       h_wr_data;
   logic [SW-1:0]  h_rd_addr;
   node_type       h_rd_data;
   logic [NW-1:0]  h_rd_raw;
   logic           s_wr_en;
   logic [HW-1:0]  s_wr_addr;
   logic [HSW-1:0] s_wr_data;
   logic [HW-1:0]  s_rd_addr;
   logic [HSW-1:0] s_rd_data;

   logic [SW-1:0]  parent_idx;
   logic [SW-1:0]  last_idx;
   logic [XW-1:0]  left_idx;
   logic [XW-1:0]  right_idx;
   logic [XW-1:0]  fill_x;
   logic           has_right;
   logic           left_wins;
   logic           right_wins;
   logic [31:0]    big_key;
   node_type       chosen;
   logic [XW-1:0]  chosen_idx;

   imeh_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_heap_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_raw)
   );

   imeh_ram #(.WIDTH(HSW), .DEPTH(HANDLES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   assign h_rd_data = node_type'(h_rd_raw);

   // index math for the walk
   assign parent_idx = (cur_ff - SW'(1)) >> 1;
   assign last_idx   = SW'(fill_ff - CW'(1));
   assign left_idx   = {1'b0, cur_ff, 1'b1};
   assign right_idx  = left_idx + XW'(1);
   assign fill_x     = XW'(fill_ff);
   assign has_right  = right_idx < fill_x;

   // pick the larger child, left on ties, stay when neither beats the entry
   assign left_wins  = $signed(left_ff.key) > $signed(elem_ff.key);
   assign big_key    = left_wins ? left_ff.key : elem_ff.key;
   assign right_wins = has_right && ($signed(h_rd_data.key) > $signed(big_key));
   assign chosen     = right_wins ? h_rd_data : left_ff;
   assign chosen_idx = right_wins ? right_idx : left_idx;

   always_comb begin
      stat.action    = action_ff;
      stat.full      = fill_ff == CW'(CAPACITY);
      stat.exhausted = next_ff == (HW+1)'(HANDLES);
      stat.empty     = fill_ff == '0;
      stat.live_ok   = s_rd_data[SW] && ({1'b0, target_ff} < next_ff);
      stat.is_last   = CW'(cur_ff) == fill_ff;
      stat.grows     = $signed(elem_ff.key) > $signed(old_key_ff);
      stat.at_root   = cur_ff == '0;
      stat.up_swap   = $signed(h_rd_data.key) < $signed(elem_ff.key);
      stat.has_left  = left_idx < fill_x;
      stat.down_stay = !left_wins && !right_wins;
   end

   // carry out the current operation
   always_comb begin
      action_in  = action_ff;
      req_in     = req_ff;
      target_in  = target_ff;
      fill_in    = fill_ff;
      next_in    = next_ff;
      cur_in     = cur_ff;
      elem_in    = elem_ff;
      left_in    = left_ff;
      old_key_in = old_key_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      h_wr_en    = 1'b0;
      h_wr_addr  = cur_ff;
      h_wr_data  = elem_ff;
      h_rd_addr  = '0;
      s_wr_en    = 1'b0;
      s_wr_addr  = elem_ff.handle;
      s_wr_data  = {1'b1, cur_ff};
      s_rd_addr  = target_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            action_in = action_type'(req_action);
            req_in    = req_node;
            target_in = req_target;
            res_in    = '0;
         end
         OP_SET_STATUS: begin
            res_in.status = cmd.code;
         end
         OP_INS_START: begin
            elem_in            = req_ff;
            elem_in.handle     = next_ff[HW-1:0];
            cur_in             = fill_ff[SW-1:0];
            fill_in            = fill_ff + CW'(1);
            next_in            = next_ff + (HW+1)'(1);
            res_in.assigned_id = next_ff[HW-1:0];
         end
         OP_POP_START: begin
            h_rd_addr = '0;
         end
         OP_POP_TOP: begin
            res_in.top_key        = h_rd_data.key;
            res_in.top_center_x   = h_rd_data.center_x;
            res_in.top_center_y   = h_rd_data.center_y;
            res_in.top_leaf_ref   = h_rd_data.leaf_ref;
            res_in.top_event_kind = h_rd_data.event_kind;
            s_wr_en   = 1'b1;
            s_wr_addr = h_rd_data.handle;
            s_wr_data = '0;
            fill_in   = fill_ff - CW'(1);
            h_rd_addr = last_idx;
            cur_in    = '0;
         end
         OP_TAKE_LAST: begin
            elem_in = h_rd_data;
         end
         OP_RD_HANDLE: begin
            s_rd_addr = target_ff;
         end
         OP_REM_START: begin
            cur_in    = s_rd_data[SW-1:0];
            s_wr_en   = 1'b1;
            s_wr_addr = target_ff;
            s_wr_data = '0;
            h_rd_addr = s_rd_data[SW-1:0];
         end
         OP_REM_OLD: begin
            old_key_in = h_rd_data.key;
            fill_in    = fill_ff - CW'(1);
            h_rd_addr  = last_idx;
         end
         OP_RD_PARENT: begin
            h_rd_addr = parent_idx;
         end
         OP_MOVE_PARENT: begin
            h_wr_en   = 1'b1;
            h_wr_data = h_rd_data;
            s_wr_en   = 1'b1;
            s_wr_addr = h_rd_data.handle;
            cur_in    = parent_idx;
         end
         OP_RD_LEFT: begin
            h_rd_addr = left_idx[SW-1:0];
         end
         OP_LATCH_LEFT: begin
            left_in   = h_rd_data;
            h_rd_addr = right_idx[SW-1:0];
         end
         OP_MOVE_CHILD: begin
            h_wr_en   = 1'b1;
            h_wr_data = chosen;
            s_wr_en   = 1'b1;
            s_wr_addr = chosen.handle;
            cur_in    = chosen_idx[SW-1:0];
         end
         OP_PLACE: begin
            h_wr_en = 1'b1;
            s_wr_en = 1'b1;
         end
         OP_PUBLISH: begin
            out_in = res_ff;
         end
         default: begin
         end
      endcase
   end

   // hold counts
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         next_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         next_ff <= next_in;
      end
   end

   // hold working registers
   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      req_ff     <= req_in;
      target_ff  <= target_in;
      cur_ff     <= cur_in;
      elem_ff    <= elem_in;
      left_ff    <= left_in;
      old_key_ff <= old_key_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign out_word = out_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("heap fill beyond capacity");
   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= (HW+1)'(HANDLES))
      else $error("handle counter beyond handle space");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
      (fill_ff == $past(fill_ff) + CW'(1) || fill_ff == $past(fill_ff) - CW'(1)))
      else $error("heap fill moved by more than one");
`endif

endmodule

// File: hw/rtl/imeh_ctrl.sv
// Heap controller: sequences insert, pop and remove over the datapath.
module imeh_ctrl import imeh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_POP1,
      S_POP2,
      S_REM1,
      S_REM2,
      S_REM3,
      S_REM4,
      S_UP,
      S_UP2,
      S_DOWN,
      S_DOWN2,
      S_DOWN3,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath operation
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NOP;
      cmd.code     = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.action)
               ACT_INSERT: begin
                  if (stat.full) begin
                     cmd.op   = OP_SET_STATUS;
                     cmd.code = ST_FULL;
                     state_in = S_RESP;
                  end else if (stat.exhausted) begin
                     cmd.op   = OP_SET_STATUS;
                     cmd.code = ST_EXHAUSTED;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = OP_INS_START;
                     state_in = S_UP;
                  end
               end
               ACT_POP: begin
                  if (stat.empty) begin
                     cmd.op   = OP_SET_STATUS;
                     cmd.code = ST_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = OP_POP_START;
                     state_in = S_POP1;
                  end
               end
               ACT_REMOVE: begin
                  cmd.op   = OP_RD_HANDLE;
                  state_in = S_REM1;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_POP1: begin
            cmd.op   = OP_POP_TOP;
            state_in = S_POP2;
         end
         S_POP2: begin
            if (stat.empty) begin
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_TAKE_LAST;
               state_in = S_DOWN;
            end
         end
         S_REM1: begin
            if (stat.live_ok) begin
               cmd.op   = OP_REM_START;
               state_in = S_REM2;
            end else begin
               cmd.op   = OP_SET_STATUS;
               cmd.code = ST_DEAD;
               state_in = S_RESP;
            end
         end
         S_REM2: begin
            cmd.op   = OP_REM_OLD;
            state_in = S_REM3;
         end
         S_REM3: begin
            if (stat.is_last) begin
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_TAKE_LAST;
               state_in = S_REM4;
            end
         end
         S_REM4: begin
            state_in = stat.grows ? S_UP : S_DOWN;
         end
         S_UP: begin
            if (stat.at_root) begin
               cmd.op   = OP_PLACE;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_RD_PARENT;
               state_in = S_UP2;
            end
         end
         S_UP2: begin
            if (stat.up_swap) begin
               cmd.op   = OP_MOVE_PARENT;
               state_in = S_UP;
            end else begin
               cmd.op   = OP_PLACE;
               state_in = S_RESP;
            end
         end
         S_DOWN: begin
            if (stat.has_left) begin
               cmd.op   = OP_RD_LEFT;
               state_in = S_DOWN2;
            end else begin
               cmd.op   = OP_PLACE;
               state_in = S_RESP;
            end
         end
         S_DOWN2: begin
            cmd.op   = OP_LATCH_LEFT;
            state_in = S_DOWN3;
         end
         S_DOWN3: begin
            if (stat.down_stay) begin
               cmd.op   = OP_PLACE;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_MOVE_CHILD;
               state_in = S_DOWN;
            end
         end
         S_RESP: begin
            // publish once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/indexed_max_event_heap.sv
// Top level of the indexed max event heap.
// Indexed binary max-heap of up to CAPACITY events keyed by a signed Q16.16 value;
// one request (insert, pop or remove by handle) is worked at a time and gives
// exactly one response word. Cost is set by the heap memory with one read and one
// write port and registered read. An entry moves at most log2(CAPACITY) levels, 8
// at the default size. An insert lets the new entry rise; a pop lets the last
// entry sink from the root unless the pop empties the heap; a remove lets the
// last entry rise or sink into the freed slot unless the removed entry sat in the
// last slot. A full, empty, undefined or dead-handle request answers with a status
// and moves no entry.
// The next request is taken while the previous response still waits.
// Handles run from 0 to 1023 and are never reused; no clearing pass after reset.
module indexed_max_event_heap import imeh_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input logic         clock,
   input logic         reset,
   imeh_req_if.sink    req_ch,
   imeh_rsp_if.source  rsp_ch
);

   dp_cmd_type   cmd;
   dp_stat_type  stat;
   node_type     req_node;
   rsp_word_type out_word;

   // pack the request word
   always_comb begin
      req_node.key        = req_ch.key;
      req_node.center_x   = req_ch.center_x;
      req_node.center_y   = req_ch.center_y;
      req_node.leaf_ref   = req_ch.leaf_ref;
      req_node.event_kind = req_ch.event_kind;
      req_node.handle     = '0;
   end

   imeh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   imeh_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_ch.action),
      .req_node   (req_node),
      .req_target (req_ch.target_id),
      .out_word   (out_word)
   );

   // drive the response word
   assign rsp_ch.status         = out_word.status;
   assign rsp_ch.assigned_id    = out_word.assigned_id;
   assign rsp_ch.top_key        = out_word.top_key;
   assign rsp_ch.top_center_x   = out_word.top_center_x;
   assign rsp_ch.top_center_y   = out_word.top_center_y;
   assign rsp_ch.top_leaf_ref   = out_word.top_leaf_ref;
   assign rsp_ch.top_event_kind = out_word.top_event_kind;

endmodule
